@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked helpers for concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/pnf_pkg.sv @@
// ----------------------------------------------------------------------------
// pnf_pkg
// shared types, constants and the permutation table of the fractal noise block
// ----------------------------------------------------------------------------
package pnf_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned TDATA_IN_W = 96;
  localparam int unsigned TDATA_OUT_W = 24;
  localparam int unsigned OUT_W      = 18;
  localparam int unsigned OCT_W      = 4;
  localparam int unsigned LAC_W      = 16;
  localparam int unsigned LAC_FRAC   = 12;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // datapath sizes
  localparam int unsigned LANES  = 4;
  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned GC_W   = FRAC_BITS + 2;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned ASUM_W = 20;
  localparam int unsigned DIV_W  = SUM_W;
  localparam int unsigned DCNT_W = $clog2(DIV_W + 1);

  localparam logic [FREQ_W-1:0] FREQ_INIT = FREQ_W'(1 << FRAC_BITS);
  localparam logic [AMP_W-1:0]  AMP_INIT  = AMP_W'(32768);
  localparam logic signed [VAL_W-1:0] FADE_A = VAL_W'(15 * (1 << FRAC_BITS));
  localparam logic signed [VAL_W-1:0] FADE_B = VAL_W'(10 * (1 << FRAC_BITS));
  localparam logic signed [GC_W-1:0]  ONE_GC = GC_W'(1 << FRAC_BITS);

  localparam logic [DIV_W-1:0] POS_LIM = DIV_W'(2 ** (OUT_W - 1) - 1);
  localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(2 ** (OUT_W - 1));
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  localparam logic [31:0] PERM_SEED = 32'd2166136261;
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;
  localparam logic [3:0] H_SEL_Y  = 4'd8;
  localparam logic [3:0] H_SEL_V  = 4'd4;
  localparam logic [3:0] H_X_LO   = 4'd12;
  localparam logic [3:0] H_X_HI   = 4'd14;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OCTAVES    = 2'd0,
    CFG_LACUNARITY = 2'd1,
    CFG_GAIN       = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OCT,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    STEP_COORD,
    STEP_FADE1,
    STEP_FADE2,
    STEP_FADE3,
    STEP_FADE4,
    STEP_FADE5,
    STEP_LERP1,
    STEP_LERP2,
    STEP_LERP3,
    STEP_ACC
  } step_e;

  typedef struct packed {
    logic  load;
    logic  step_en;
    step_e step;
    logic  div_init;
    logic  div_step;
    logic  out_load;
  } dp_cmd_t;

  typedef logic [TABLE_SIZE-1:0][IDX_W-1:0] perm_t;

  // shift-subtract remainder, used only while building the table
  function automatic logic [31:0] mod_u32(input logic [31:0] num, input logic [31:0] den);
    logic [32:0] r;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      r = {r[31:0], num[k]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
      end
    end
    return r[31:0];
  endfunction

  function automatic perm_t build_perm();
    perm_t              p;
    logic [31:0]        rng;
    logic [31:0]        j;
    logic [IDX_W-1:0]   t;
    rng = PERM_SEED;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      p[i] = IDX_W'(i);
    end
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      rng = rng ^ (rng << XS_A);
      rng = rng ^ (rng >> XS_B);
      rng = rng ^ (rng << XS_C);
      j = mod_u32(rng, 32'(i + 1));
      t = p[i];
      p[i] = p[j[IDX_W-1:0]];
      p[j[IDX_W-1:0]] = t;
    end
    return p;
  endfunction

  localparam perm_t PERM = build_perm();

  // one of the twelve cube-edge gradients dotted with the corner offset
  function automatic logic signed [GC_W:0] edge_grad(input logic [3:0] h,
                                                     input logic signed [GC_W-1:0] x,
                                                     input logic signed [GC_W-1:0] y,
                                                     input logic signed [GC_W-1:0] z);
    logic signed [GC_W-1:0] u;
    logic signed [GC_W-1:0] v;
    logic signed [GC_W:0]   ue;
    logic signed [GC_W:0]   ve;
    u = (h < H_SEL_Y) ? x : y;
    if (h < H_SEL_V) begin
      v = y;
    end else if (h == H_X_LO || h == H_X_HI) begin
      v = x;
    end else begin
      v = z;
    end
    ue = {u[GC_W-1], u};
    ve = {v[GC_W-1], v};
    return (h[0] ? -ue : ue) + (h[1] ? -ve : ve);
  endfunction

endpackage

@@ hdl/pnf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pnf_ctrl
// sequencer: octave loop, per-octave step order, divider count, output valid
// ----------------------------------------------------------------------------
module pnf_ctrl #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  input  logic [pnf_pkg::OCT_W-1:0]  octave_count_i,
  output pnf_pkg::dp_cmd_t           cmd_o
);

  localparam int unsigned OCW = $clog2(MAX_OCTAVES + 1);
  localparam logic [pnf_pkg::OCT_W:0] MAX_EXT = (pnf_pkg::OCT_W + 1)'(MAX_OCTAVES);

  pnf_pkg::state_e state_q, state_d;
  pnf_pkg::step_e  step_q, step_d;
  logic [OCW-1:0]  oct_q, oct_d;
  logic [pnf_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  logic            ovalid_q, ovalid_d;
  logic [pnf_pkg::OCT_W:0] oc_ext;
  logic [OCW-1:0]  oct_n;
  logic            out_load;

  // octave counts above the limit run the limit
  assign oc_ext = {1'b0, octave_count_i};
  assign oct_n  = OCW'((oc_ext > MAX_EXT) ? MAX_EXT : oc_ext);
  assign out_load = (state_q == pnf_pkg::ST_DONE) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    oct_d   = oct_q;
    dcnt_d  = dcnt_q;
    unique case (state_q)
      pnf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          step_d  = pnf_pkg::STEP_COORD;
          oct_d   = oct_n;
          state_d = (oct_n == '0) ? pnf_pkg::ST_DINIT : pnf_pkg::ST_OCT;
        end
      end
      pnf_pkg::ST_OCT: begin
        if (step_q == pnf_pkg::STEP_ACC) begin
          step_d = pnf_pkg::STEP_COORD;
          oct_d  = oct_q - OCW'(1);
          if (oct_q == OCW'(1)) begin
            state_d = pnf_pkg::ST_DINIT;
          end
        end else begin
          step_d = pnf_pkg::step_e'(step_q + 4'd1);
        end
      end
      pnf_pkg::ST_DINIT: begin
        dcnt_d  = '0;
        state_d = pnf_pkg::ST_DIV;
      end
      pnf_pkg::ST_DIV: begin
        dcnt_d = dcnt_q + pnf_pkg::DCNT_W'(1);
        if (dcnt_q == pnf_pkg::DCNT_W'(pnf_pkg::DIV_W - 1)) begin
          state_d = pnf_pkg::ST_DONE;
        end
      end
      pnf_pkg::ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          state_d = pnf_pkg::ST_IDLE;
        end
      end
      default: state_d = pnf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == pnf_pkg::ST_IDLE);
    cmd_o.load     = (state_q == pnf_pkg::ST_IDLE) && in_valid_i;
    cmd_o.step_en  = (state_q == pnf_pkg::ST_OCT);
    cmd_o.step     = step_q;
    cmd_o.div_init = (state_q == pnf_pkg::ST_DINIT);
    cmd_o.div_step = (state_q == pnf_pkg::ST_DIV);
    cmd_o.out_load = out_load;
    ovalid_d       = out_load || (ovalid_q && !out_ready_i);
    out_valid_o    = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pnf_pkg::ST_IDLE;
      step_q   <= pnf_pkg::STEP_COORD;
      oct_q    <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      oct_q    <= oct_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

@@ hdl/pnf_datapath.sv @@
// ----------------------------------------------------------------------------
// pnf_datapath
// four shared multiplier lanes, hash chain, octave accumulator, bit-serial divider
// ----------------------------------------------------------------------------
module pnf_datapath (
  input  logic                                clk_i,
  input  pnf_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [pnf_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [pnf_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [pnf_pkg::COORD_W-1:0]  coord_z_i,
  input  logic [pnf_pkg::LAC_W-1:0]           lacunarity_i,
  input  logic [pnf_pkg::GAIN_W-1:0]          gain_i,
  output logic signed [pnf_pkg::OUT_W-1:0]    noise_value_o
);

  localparam int unsigned F  = pnf_pkg::FRAC_BITS;
  localparam int unsigned VW = pnf_pkg::VAL_W;
  localparam int unsigned MW = pnf_pkg::MUL_W;
  localparam int unsigned NL = pnf_pkg::LANES;
  localparam int unsigned IW = pnf_pkg::IDX_W;
  localparam int unsigned GW = pnf_pkg::GC_W;

  logic signed [pnf_pkg::COORD_W-1:0] crd_q [3];
  logic [pnf_pkg::FREQ_W-1:0]  freq_q, freq_d;
  logic [pnf_pkg::AMP_W-1:0]   amp_q;
  logic signed [pnf_pkg::SUM_W-1:0] sum_q;
  logic [pnf_pkg::ASUM_W-1:0]  asum_q;
  logic [IW-1:0]               idx_q [3];
  logic [F-1:0]                frac_q [3];
  logic [IW-1:0]               ha_q, hb_q, ha_d, hb_d;
  logic [IW-1:0]               hq_q [4];
  logic [IW-1:0]               hq_d [4];
  logic signed [VW-1:0]        r_q [3];
  logic signed [VW-1:0]        c_q [3];
  logic signed [VW-1:0]        fade_q [3];
  logic signed [VW-1:0]        g_q [8];
  logic signed [VW-1:0]        g_d [8];
  logic signed [VW-1:0]        x_q [NL];
  logic signed [VW-1:0]        tv [3];

  logic signed [MW-1:0]               op_a [NL];
  logic signed [MW-1:0]               op_b [NL];
  logic signed [VW-1:0]               add_v [NL];
  logic signed [pnf_pkg::PROD_W-1:0]  prod [NL];
  logic signed [VW-1:0]               res [NL];

  logic signed [GW-1:0] pf [3];
  logic signed [GW-1:0] pg [3];

  logic [pnf_pkg::DIV_W-1:0]  dq_q;
  logic [pnf_pkg::ASUM_W-1:0] drem_q;
  logic                       dneg_q;
  logic [pnf_pkg::ASUM_W:0]   dshift, dtrial;
  logic                       dge;
  logic signed [pnf_pkg::OUT_W-1:0] sat_v, noise_q;

  // operand selection per step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tv[k] = $signed(VW'(frac_q[k]));
    end
    for (int k = 0; k < NL; k++) begin
      op_a[k]  = '0;
      op_b[k]  = '0;
      add_v[k] = '0;
    end
    unique case (cmd_i.step)
      pnf_pkg::STEP_COORD: begin
        for (int k = 0; k < 3; k++) begin
          op_a[k] = MW'(crd_q[k]);
          op_b[k] = $signed(MW'(freq_q));
        end
      end
      pnf_pkg::STEP_FADE1: begin
        for (int k = 0; k < 3; k++) begin
          op_a[k] = MW'(tv[k]);
          op_b[k] = MW'((tv[k] <<< 2) + (tv[k] <<< 1) - pnf_pkg::FADE_A);
        end
      end
      pnf_pkg::STEP_FADE2: begin
        for (int k = 0; k < 3; k++) begin
          op_a[k] = MW'(tv[k]);
          op_b[k] = MW'(r_q[k] + pnf_pkg::FADE_B);
        end
      end
      pnf_pkg::STEP_FADE3: begin
        for (int k = 0; k < 3; k++) begin
          op_a[k] = MW'(tv[k]);
          op_b[k] = MW'(tv[k]);
        end
      end
      pnf_pkg::STEP_FADE4: begin
        for (int k = 0; k < 3; k++) begin
          op_a[k] = MW'(r_q[k]);
          op_b[k] = MW'(tv[k]);
        end
      end
      pnf_pkg::STEP_FADE5: begin
        for (int k = 0; k < 3; k++) begin
          op_a[k] = MW'(r_q[k]);
          op_b[k] = MW'(c_q[k]);
        end
      end
      pnf_pkg::STEP_LERP1: begin
        for (int k = 0; k < NL; k++) begin
          op_a[k]  = MW'(fade_q[0]);
          op_b[k]  = MW'(g_q[2*k+1] - g_q[2*k]);
          add_v[k] = g_q[2*k];
        end
      end
      pnf_pkg::STEP_LERP2: begin
        for (int k = 0; k < 2; k++) begin
          op_a[k]  = MW'(fade_q[1]);
          op_b[k]  = MW'(x_q[2*k+1] - x_q[2*k]);
          add_v[k] = x_q[2*k];
        end
      end
      pnf_pkg::STEP_LERP3: begin
        op_a[0]  = MW'(fade_q[2]);
        op_b[0]  = MW'(x_q[1] - x_q[0]);
        add_v[0] = x_q[0];
      end
      pnf_pkg::STEP_ACC: begin
        op_a[0] = $signed(MW'(amp_q));
        op_b[0] = MW'(x_q[0]);
        op_a[1] = $signed(MW'(amp_q));
        op_b[1] = $signed(MW'(gain_i));
        op_a[2] = $signed(MW'(freq_q));
        op_b[2] = $signed(MW'(lacunarity_i));
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      prod[k] = op_a[k] * op_b[k];
      res[k]  = add_v[k] + $signed(prod[k][F +: VW]);
    end
  end

  // next frequency, saturated to the register width
  always_comb begin
    if (|prod[2][pnf_pkg::LAC_FRAC + pnf_pkg::FREQ_W +: pnf_pkg::LAC_W]) begin
      freq_d = '1;
    end else begin
      freq_d = prod[2][pnf_pkg::LAC_FRAC +: pnf_pkg::FREQ_W];
    end
  end

  // hash chain through the permutation table
  always_comb begin
    ha_d = pnf_pkg::PERM[idx_q[0]] + idx_q[1];
    hb_d = pnf_pkg::PERM[IW'(idx_q[0] + IW'(1))] + idx_q[1];
    hq_d[0] = pnf_pkg::PERM[ha_q] + idx_q[2];
    hq_d[1] = pnf_pkg::PERM[IW'(ha_q + IW'(1))] + idx_q[2];
    hq_d[2] = pnf_pkg::PERM[hb_q] + idx_q[2];
    hq_d[3] = pnf_pkg::PERM[IW'(hb_q + IW'(1))] + idx_q[2];
    for (int k = 0; k < 3; k++) begin
      pf[k] = $signed(GW'(frac_q[k]));
      pg[k] = pf[k] - pnf_pkg::ONE_GC;
    end
    // corner order: aa ba ab bb, then the same four one step up in z
    g_d[0] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[hq_q[0]][3:0], pf[0], pf[1], pf[2]));
    g_d[1] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[hq_q[2]][3:0], pg[0], pf[1], pf[2]));
    g_d[2] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[hq_q[1]][3:0], pf[0], pg[1], pf[2]));
    g_d[3] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[hq_q[3]][3:0], pg[0], pg[1], pf[2]));
    g_d[4] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[IW'(hq_q[0] + IW'(1))][3:0],
                                    pf[0], pf[1], pg[2]));
    g_d[5] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[IW'(hq_q[2] + IW'(1))][3:0],
                                    pg[0], pf[1], pg[2]));
    g_d[6] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[IW'(hq_q[1] + IW'(1))][3:0],
                                    pf[0], pg[1], pg[2]));
    g_d[7] = VW'(pnf_pkg::edge_grad(pnf_pkg::PERM[IW'(hq_q[3] + IW'(1))][3:0],
                                    pg[0], pg[1], pg[2]));
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    dshift = {drem_q, dq_q[pnf_pkg::DIV_W-1]};
    dge    = dshift >= {1'b0, asum_q};
    dtrial = dshift - {1'b0, asum_q};
    if (asum_q == '0) begin
      sat_v = '0;
    end else if (!dneg_q) begin
      sat_v = (dq_q > pnf_pkg::POS_LIM) ? pnf_pkg::OUT_MAX : dq_q[pnf_pkg::OUT_W-1:0];
    end else begin
      sat_v = (dq_q > pnf_pkg::NEG_LIM) ? pnf_pkg::OUT_MIN : -dq_q[pnf_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      crd_q[0] <= coord_x_i;
      crd_q[1] <= coord_y_i;
      crd_q[2] <= coord_z_i;
      freq_q   <= pnf_pkg::FREQ_INIT;
      amp_q    <= pnf_pkg::AMP_INIT;
      sum_q    <= '0;
      asum_q   <= '0;
    end
    if (cmd_i.step_en) begin
      unique case (cmd_i.step)
        pnf_pkg::STEP_COORD: begin
          for (int k = 0; k < 3; k++) begin
            idx_q[k]  <= prod[k][2*F +: IW];
            frac_q[k] <= prod[k][F +: F];
          end
        end
        pnf_pkg::STEP_FADE1: begin
          for (int k = 0; k < 3; k++) begin
            r_q[k] <= res[k];
          end
          ha_q <= ha_d;
          hb_q <= hb_d;
        end
        pnf_pkg::STEP_FADE2: begin
          for (int k = 0; k < 3; k++) begin
            c_q[k] <= res[k];
          end
          for (int k = 0; k < 4; k++) begin
            hq_q[k] <= hq_d[k];
          end
        end
        pnf_pkg::STEP_FADE3: begin
          for (int k = 0; k < 3; k++) begin
            r_q[k] <= res[k];
          end
          for (int k = 0; k < 8; k++) begin
            g_q[k] <= g_d[k];
          end
        end
        pnf_pkg::STEP_FADE4: begin
          for (int k = 0; k < 3; k++) begin
            r_q[k] <= res[k];
          end
        end
        pnf_pkg::STEP_FADE5: begin
          for (int k = 0; k < 3; k++) begin
            fade_q[k] <= res[k];
          end
        end
        pnf_pkg::STEP_LERP1: begin
          for (int k = 0; k < NL; k++) begin
            x_q[k] <= res[k];
          end
        end
        pnf_pkg::STEP_LERP2: begin
          x_q[0] <= res[0];
          x_q[1] <= res[1];
        end
        pnf_pkg::STEP_LERP3: begin
          x_q[0] <= res[0];
        end
        pnf_pkg::STEP_ACC: begin
          sum_q  <= sum_q + $signed(prod[0][pnf_pkg::SUM_W-1:0]);
          asum_q <= asum_q + pnf_pkg::ASUM_W'(amp_q);
          amp_q  <= prod[1][pnf_pkg::GAIN_FRAC +: pnf_pkg::AMP_W];
          freq_q <= freq_d;
        end
        default: ;
      endcase
    end
    if (cmd_i.div_init) begin
      dneg_q <= sum_q[pnf_pkg::SUM_W-1];
      dq_q   <= sum_q[pnf_pkg::SUM_W-1] ? pnf_pkg::DIV_W'(-sum_q) : pnf_pkg::DIV_W'(sum_q);
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      drem_q <= dge ? dtrial[pnf_pkg::ASUM_W-1:0] : dshift[pnf_pkg::ASUM_W-1:0];
      dq_q   <= {dq_q[pnf_pkg::DIV_W-2:0], dge};
    end
    if (cmd_i.out_load) begin
      noise_q <= sat_v;
    end
  end

  assign noise_value_o = noise_q;

endmodule

@@ hdl/perlin_noise_3d_fbm.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_3d_fbm
// fractal improved perlin noise of a 3d point, normalized to signed q2.16
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one point per transfer (x, y, z in signed q16.16).
//   master stream returns one noise value per point, in input order.
//   cfg port writes octave count, lacunarity and gain; the user must write
//   them only while the block is idle, the block itself does not enforce it.
// timing:
//   one point at a time. each octave runs the coordinate scale, five fade
//   steps, three blend levels and the accumulate on four shared multiplier
//   lanes, then a divider setup step, the normalizing divide (one quotient
//   bit per cycle) and a final step that loads the output register.
// reset:
//   clears the sequencer and the output valid; registers return to one octave,
//   lacunarity 2.0 and gain 0.5.
// stall:
//   a finished result waits in the output register; the next point is taken
//   meanwhile and its result is held until the register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module perlin_noise_3d_fbm #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
  input  logic [pnf_pkg::TDATA_IN_W-1:0]       s_axis_tdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [17:0] noise_value, [23:18] zero
  output logic [pnf_pkg::TDATA_OUT_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_we_i,
  input  logic [pnf_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [pnf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  logic [pnf_pkg::OCT_W-1:0]  octaves_q;
  logic [pnf_pkg::LAC_W-1:0]  lacunarity_q;
  logic [pnf_pkg::GAIN_W-1:0] gain_q;
  pnf_pkg::dp_cmd_t           cmd;
  logic signed [pnf_pkg::OUT_W-1:0] noise_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q    <= pnf_pkg::OCT_W'(1);
      lacunarity_q <= pnf_pkg::LAC_W'(8192);
      gain_q       <= pnf_pkg::GAIN_W'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pnf_pkg::CFG_OCTAVES:    octaves_q    <= cfg_wdata_i[pnf_pkg::OCT_W-1:0];
        pnf_pkg::CFG_LACUNARITY: lacunarity_q <= cfg_wdata_i[pnf_pkg::LAC_W-1:0];
        pnf_pkg::CFG_GAIN:       gain_q       <= cfg_wdata_i[pnf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  pnf_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .octave_count_i (octaves_q),
    .cmd_o          (cmd)
  );

  pnf_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .coord_x_i     ($signed(s_axis_tdata_i[31:0])),
    .coord_y_i     ($signed(s_axis_tdata_i[63:32])),
    .coord_z_i     ($signed(s_axis_tdata_i[95:64])),
    .lacunarity_i  (lacunarity_q),
    .gain_i        (gain_q),
    .noise_value_o (noise_value)
  );

  assign m_axis_tdata_o = {{(pnf_pkg::TDATA_OUT_W - pnf_pkg::OUT_W){1'b0}}, noise_value};

  // the input closes right after a point is taken
  `ASSERT_CLK(a_busy_after_take, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "input open right after a transfer")
  // a new result only appears after the block was busy
  `ASSERT_CLK(a_result_from_work, $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o), "result without work")
  // the output register is loaded only when it is free or being drained
  `ASSERT_NEVER(a_no_overwrite, cmd.out_load && m_axis_tvalid_o && !m_axis_tready_i, "result overwritten")

endmodule

@@ dv/perlin_noise_3d_fbm_checker.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_3d_fbm_checker
// watches the point and noise streams and the cfg port, predicts the fractal
// noise of every accepted point and compares it with the returned value
// ----------------------------------------------------------------------------
module perlin_noise_3d_fbm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
  input  logic [pnf_pkg::TDATA_IN_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_i,
  // [17:0] noise_value, [23:18] zero
  input  logic [pnf_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_i,
  input  logic                               m_axis_tvalid_i,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_we_i,
  input  logic [pnf_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [pnf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output int unsigned                        fail_cnt_o,
  output int unsigned                        pending_o
);

  localparam int unsigned OCT_LIMIT = 8;
  localparam longint      ONE       = 64'sd1 <<< 16;

  logic [7:0]                perm_tbl [256];
  logic [3:0]                octaves_q;
  logic [15:0]               lac_q;
  logic [15:0]               gain_q;
  logic [pnf_pkg::OUT_W-1:0] noise_q [$];
  int unsigned               n_fail;

  assign fail_cnt_o = n_fail;
  assign pending_o  = noise_q.size();

  // fisher-yates shuffle of the identity, xorshift32 picks the partner
  initial begin
    logic [31:0] rng;
    logic [31:0] j;
    logic [7:0]  t;
    rng = 32'd2166136261;
    for (int i = 0; i < 256; i++) perm_tbl[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      rng = rng ^ (rng << 13);
      rng = rng ^ (rng >> 17);
      rng = rng ^ (rng << 5);
      j = rng % 32'(i + 1);
      t = perm_tbl[i];
      perm_tbl[i] = perm_tbl[j[7:0]];
      perm_tbl[j[7:0]] = t;
    end
  end

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint smooth(input longint t);
    longint a, b, c, t3;
    a  = 6 * t - 15 * ONE;
    b  = fx_mul(t, a) + 10 * ONE;
    c  = fx_mul(t, b);
    t3 = fx_mul(fx_mul(t, t), t);
    return fx_mul(t3, c);
  endfunction

  function automatic longint grad_dot(input logic [7:0] hv, input longint x,
                                      input longint y, input longint z);
    logic [3:0] h;
    longint     u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint t);
    return a + fx_mul(t, b - a);
  endfunction

  function automatic logic [7:0] perm_at(input int unsigned idx);
    return perm_tbl[idx[7:0]];
  endfunction

  // one octave, inputs carry 32 fraction bits
  function automatic longint lattice_noise(input logic [63:0] px, input logic [63:0] py,
                                           input logic [63:0] pz);
    int unsigned cx, cy, cz, a, b, aa, ab, ba, bb;
    longint xf, yf, zf, xg, yg, zg, u, v, w, x1, x2, x3, x4;
    cx = px[39:32]; cy = py[39:32]; cz = pz[39:32];
    xf = px[31:16]; yf = py[31:16]; zf = pz[31:16];
    xg = xf - ONE; yg = yf - ONE; zg = zf - ONE;
    u = smooth(xf); v = smooth(yf); w = smooth(zf);
    a  = perm_at(cx) + cy;
    aa = perm_at(a) + cz;
    ab = perm_at(a + 1) + cz;
    b  = perm_at(cx + 1) + cy;
    ba = perm_at(b) + cz;
    bb = perm_at(b + 1) + cz;
    x1 = blend(grad_dot(perm_at(aa), xf, yf, zf), grad_dot(perm_at(ba), xg, yf, zf), u);
    x2 = blend(grad_dot(perm_at(ab), xf, yg, zf), grad_dot(perm_at(bb), xg, yg, zf), u);
    x3 = blend(grad_dot(perm_at(aa + 1), xf, yf, zg),
               grad_dot(perm_at(ba + 1), xg, yf, zg), u);
    x4 = blend(grad_dot(perm_at(ab + 1), xf, yg, zg),
               grad_dot(perm_at(bb + 1), xg, yg, zg), u);
    return blend(blend(x1, x2, v), blend(x3, x4, v), w);
  endfunction

  function automatic logic [pnf_pkg::OUT_W-1:0] fbm_value(input logic [95:0] pt);
    longint      cx, cy, cz, freq, amp, amp_sum, acc, res;
    int unsigned n;
    cx = longint'($signed(pt[31:0]));
    cy = longint'($signed(pt[63:32]));
    cz = longint'($signed(pt[95:64]));
    n = (octaves_q > OCT_LIMIT) ? OCT_LIMIT : octaves_q;
    freq = ONE; amp = 32768; amp_sum = 0; acc = 0; res = 0;
    for (int i = 0; i < n; i++) begin
      acc += amp * lattice_noise(cx * freq, cy * freq, cz * freq);
      amp_sum += amp;
      freq = (freq * lac_q) >> 12;
      if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
      amp = (amp * gain_q) >> 16;
    end
    if (amp_sum != 0) res = acc / amp_sum;
    if (res > 131071) res = 131071;
    if (res < -131072) res = -131072;
    return res[pnf_pkg::OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q <= 4'd1;
      lac_q     <= 16'd8192;
      gain_q    <= 16'd32768;
      noise_q.delete();
      n_fail    = 0;
    end else begin
      if (cfg_we_i) begin
        case (pnf_pkg::cfg_idx_e'(cfg_addr_i))
          pnf_pkg::CFG_OCTAVES:    octaves_q <= cfg_wdata_i[3:0];
          pnf_pkg::CFG_LACUNARITY: lac_q     <= cfg_wdata_i;
          pnf_pkg::CFG_GAIN:       gain_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) noise_q.push_back(fbm_value(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (noise_q.size() == 0) begin
          report_mismatch($sformatf("noise transfer %0h with nothing expected",
                                    m_axis_tdata_i));
        end else begin
          if (m_axis_tdata_i[pnf_pkg::OUT_W-1:0] !== noise_q[0])
            report_mismatch($sformatf("noise_value got %0h want %0h",
                                      m_axis_tdata_i[pnf_pkg::OUT_W-1:0], noise_q[0]));
          void'(noise_q.pop_front());
        end
      end
    end
  end

endmodule

@@ dv/perlin_noise_3d_fbm_tb.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_3d_fbm_tb
// drives points through the fractal noise block across several octave, lacunarity
// and gain settings with random idling on both streams; the checker judges
// ----------------------------------------------------------------------------
module perlin_noise_3d_fbm_tb;

  localparam int unsigned SETTLE    = 140;
  localparam int unsigned MAX_CYCLE = 3000000;

  logic                             clk_i;
  logic                             rst_ni;
  logic [pnf_pkg::TDATA_IN_W-1:0]   s_tdata;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [pnf_pkg::TDATA_OUT_W-1:0]  m_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  logic                             cfg_we;
  logic [pnf_pkg::CFG_ADDR_W-1:0]   cfg_addr;
  logic [pnf_pkg::CFG_DATA_W-1:0]   cfg_wdata;
  int unsigned                      fail_cnt;
  int unsigned                      pending;
  int unsigned                      cycle_cnt;
  int unsigned                      stall_left;
  logic                             idle_on;

  perlin_noise_3d_fbm i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  perlin_noise_3d_fbm_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall after each noise transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      int unsigned n;
      n = idle_on ? $urandom_range(0, 11) : 0;
      if (n > 0) begin
        m_tready   <= 1'b0;
        stall_left <= n;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_tready <= 1'b1;
    end
  end

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= {z, y, x};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // drain, let the block settle, then write all three registers
  task automatic set_regs(input logic [3:0] oct, input logic [15:0] lac,
                          input logic [15:0] gn);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we <= 1'b1; cfg_addr <= pnf_pkg::CFG_OCTAVES; cfg_wdata <= 16'(oct);
    @(posedge clk_i);
    cfg_addr <= pnf_pkg::CFG_LACUNARITY; cfg_wdata <= lac;
    @(posedge clk_i);
    cfg_addr <= pnf_pkg::CFG_GAIN; cfg_wdata <= gn;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      2:       return {16'($urandom_range(0, 255) - 128), 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  task automatic random_points(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    s_tdata   = '0;
    s_tvalid  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = pnf_pkg::CFG_OCTAVES;
    cfg_wdata = '0;
    cycle_cnt = 0;
    idle_on   = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, lattice points, fractions, coordinate extremes
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
    send_point(32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0123_4567);
    send_point(32'hFFFF_8000, 32'h00FF_8000, 32'h0100_8000);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000);
    // all octaves with max lacunarity and gain: frequency saturates
    set_regs(4'd8, 16'hFFFF, 16'hFFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000);
    send_point(32'h0012_3456, 32'h0003_8000, 32'hFFF0_4000);
    // zero octaves
    set_regs(4'd0, 16'd8192, 16'd32768);
    send_point(32'h0000_8000, 32'h0001_4000, 32'h0002_2000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    // octave count above the limit, zero lacunarity
    set_regs(4'd15, 16'd0, 16'd40000);
    send_point(32'h0000_8000, 32'h0001_4000, 32'h0002_2000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1111);
    // zero gain
    set_regs(4'd5, 16'd12000, 16'd0);
    send_point(32'h0000_8000, 32'h0001_4000, 32'h0002_2000);
    send_point(32'hFFFE_C000, 32'h0003_3333, 32'h7000_0000);

    set_regs(4'd1, 16'd8192, 16'd32768);
    random_points(300);
    set_regs(4'd3, 16'd8192, 16'd32768);
    random_points(200);
    set_regs(4'd8, 16'hFFFF, 16'hFFFF);
    random_points(100);
    set_regs(4'd0, 16'd4096, 16'd0);
    random_points(60);
    set_regs(4'd2, 16'($urandom()), 16'($urandom()));
    random_points(180);
    set_regs(4'd12, 16'($urandom()), 16'($urandom()));
    random_points(80);
    set_regs(4'd4, 16'd0, 16'd65535);
    random_points(100);
    set_regs(4'd6, 16'd1, 16'd1);
    random_points(60);

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
